FILE: hw/rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  // Field widths: Q16.16 data words and the Q0.16 gain with one extra bit for unity.
  localparam int unsigned DW    = 32;
  localparam int unsigned KW    = 17;
  localparam int unsigned AW    = 4;
  localparam int unsigned CNT_W = 5;

  // The gain value that stands for one.
  localparam logic [KW-1:0] Q_ONE = 17'h10000;

  // Configuration register indexes (word address).
  typedef enum logic [1:0] {
    REG_Q  = 2'd0,
    REG_R  = 2'd1,
    REG_X0 = 2'd2,
    REG_P0 = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL,
    ST_HOLD
  } state_t;

  // Request and response of the serial gain divider.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] p1;
    logic [DW:0]   s;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [KW-1:0] k;
  } div_rsp_t;

  // Request and response of a serial multiplier.
  typedef struct packed {
    logic          start;
    logic [DW:0]   mcand;
    logic [KW-1:0] mplr;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [DW:0] prod;
  } mul_rsp_t;

endpackage

FILE: hw/rtl/skf_if.sv
// Valid/ready channel interfaces for measurements and filter results.
interface skf_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic [16:0]        kalman_gain;
  logic [31:0]        covariance;

  modport source (output valid, output estimate, output kalman_gain, output covariance,
                  input ready);
  modport sink   (input valid, input estimate, input kalman_gain, input covariance,
                  output ready);
endinterface

FILE: hw/rtl/skf_div.sv
// Radix-2 restoring divider that forms the gain k = floor(p1 * 2^16 / s), one bit a cycle.
module skf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  skf_pkg::div_req_t req_i,
  output skf_pkg::div_rsp_t rsp_o
);
  import skf_pkg::*;

  logic [DW+1:0]  rem_r, rem_nxt;
  logic [DW:0]    den_r, den_nxt;
  logic [KW-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           zero_r, zero_nxt;
  logic [DW+2:0]  diff;
  logic           ge;
  logic [DW+1:0]  rem_keep;

  // One trial subtraction; the dividend's low bits are all zero, so a zero shifts in.
  always_comb begin
    diff     = {1'b0, rem_r} - {2'b00, den_r};
    ge       = ~diff[DW+2];
    rem_keep = ge ? diff[DW+1:0] : rem_r;
  end

  // Step control and the quotient shift register.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (req_i.start) begin
      rem_nxt  = {2'b00, req_i.p1};
      den_nxt  = req_i.s;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(KW - 1);
      busy_nxt = 1'b1;
      zero_nxt = (req_i.s == '0);
    end else if (busy_r) begin
      rem_nxt = {rem_keep[DW:0], 1'b0};
      quo_nxt = {quo_r[KW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
  end

  // A zero denominator gives a zero gain.
  assign rsp_o.done = done_r;
  assign rsp_o.k    = zero_r ? '0 : quo_r;

endmodule

FILE: hw/rtl/skf_mul.sv
// Shift-and-add multiplier: one multiplier bit a cycle, result is the product shifted right by 16.
module skf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  skf_pkg::mul_req_t req_i,
  output skf_pkg::mul_rsp_t rsp_o
);
  import skf_pkg::*;

  logic [DW:0]      acc_r, acc_nxt;
  logic [DW:0]      mcand_r, mcand_nxt;
  logic [KW-1:0]    mplr_r, mplr_nxt;
  logic             lsb_r, lsb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW+1:0]    sum;

  // Add the multiplicand when the current multiplier bit is set.
  always_comb begin
    sum = {1'b0, acc_r} + (mplr_r[0] ? {1'b0, mcand_r} : '0);
  end

  // The accumulator shifts right each step; the last bit shifted out is product bit 16.
  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    lsb_nxt   = lsb_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req_i.start) begin
      acc_nxt   = '0;
      mcand_nxt = req_i.mcand;
      mplr_nxt  = req_i.mplr;
      lsb_nxt   = 1'b0;
      cnt_nxt   = CNT_W'(KW - 1);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = sum[DW+1:1];
      lsb_nxt  = sum[0];
      mplr_nxt = {1'b0, mplr_r[KW-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    lsb_r   <= lsb_nxt;
  end

  // A 17-bit multiplier operand no larger than unity keeps the shifted product within 33 bits.
  assign rsp_o.done = done_r;
  assign rsp_o.prod = {acc_r[DW-1:0], lsb_r};

endmodule

FILE: hw/rtl/scalar_kalman_filter_top.sv
// Top level of the scalar Kalman filter: register port, sequencer and state update.
// Each accepted measurement runs one predict/update step and yields one result transaction.
// A step runs from acceptance to a valid result as follows. The prediction state starts the
// gain divider with p + q + r. The bit-serial divider then forms the gain, one quotient bit
// a cycle. The gain is then handed to the two bit-serial multipliers. They run side by
// side for the estimate and covariance updates, one gain bit a cycle. The result is
// stored once the output register is free. The input is ready again in the cycle after the
// result is stored, so a measurement is accepted only after the previous result is stored.
// The next measurement is taken once the result is in the output register, even if the
// sink has not yet taken it. Register writes reload the estimate and covariance from the
// initial-value registers and must be made while the filter is idle.
module scalar_kalman_filter_top (
  input  logic                   clk,
  input  logic                   rst_n,
  skf_in_if.sink                 in_ch,
  skf_out_if.source              out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [skf_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import skf_pkg::*;

  state_t state_r, state_nxt;

  logic [DW-1:0] q_r, r_r, x0_r, p0_r;
  logic [DW-1:0] x_r, x_nxt, p_r, p_nxt;
  logic [DW-1:0] p1_r;
  logic [DW:0]   mag_r;
  logic          sign_r;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_x_r, out_p_r;
  logic [KW-1:0] out_k_r;

  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  logic          in_fire;
  logic          slot_free;
  logic          in_ready;
  logic          div_start, mul_start, load;

  logic [DW:0]   pq_sum;
  logic [DW-1:0] p1_now;
  logic [DW:0]   d_now;
  logic [DW:0]   mag_now;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mulx_req, mulp_req;
  mul_rsp_t mulx_rsp, mulp_rsp;

  logic signed [DW+1:0] xsum;
  logic [DW-1:0]        x_new;

  // Register port decode and read-back.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_Q:   prdata = q_r;
      REG_R:   prdata = r_r;
      REG_X0:  prdata = x0_r;
      REG_P0:  prdata = p0_r;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= 32'd65;
      r_r  <= 32'd6554;
      x0_r <= '0;
      p0_r <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_Q:   q_r  <= pwdata;
        REG_R:   r_r  <= pwdata;
        REG_X0:  x0_r <= pwdata;
        REG_P0:  p0_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Handshake status.
  assign in_fire   = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_MUL;
      ST_MUL:  if (mulx_rsp.done) state_nxt = slot_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_PRED: div_start = 1'b1;
      ST_DIV:  mul_start = div_rsp.done;
      ST_MUL:  load      = mulx_rsp.done && slot_free;
      ST_HOLD: load      = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Predicted covariance and innovation magnitude, captured with the measurement.
  always_comb begin
    pq_sum  = {1'b0, p_r} + {1'b0, q_r};
    p1_now  = pq_sum[DW] ? '1 : pq_sum[DW-1:0];
    d_now   = {in_ch.measurement[DW-1], in_ch.measurement} - {x_r[DW-1], x_r};
    mag_now = d_now[DW] ? (~d_now + 1'b1) : d_now;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_r   <= p1_now;
      mag_r  <= mag_now;
      sign_r <= d_now[DW];
    end
  end

  // Gain divider.
  assign div_req.start = div_start;
  assign div_req.p1    = p1_r;
  assign div_req.s     = {1'b0, p1_r} + {1'b0, r_r};

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Correction k * |d| and new covariance (1 - k) * p1, computed side by side.
  assign mulx_req.start = mul_start;
  assign mulx_req.mcand = mag_r;
  assign mulx_req.mplr  = div_rsp.k;
  assign mulp_req.start = mul_start;
  assign mulp_req.mcand = {1'b0, p1_r};
  assign mulp_req.mplr  = Q_ONE - div_rsp.k;

  skf_mul u_mul_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mulx_req),
    .rsp_o (mulx_rsp)
  );

  skf_mul u_mul_p (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mulp_req),
    .rsp_o (mulp_rsp)
  );

  // Apply the correction in the direction of the innovation and saturate.
  always_comb begin
    xsum = sign_r ? ($signed({{2{x_r[DW-1]}}, x_r}) - $signed({1'b0, mulx_rsp.prod}))
                  : ($signed({{2{x_r[DW-1]}}, x_r}) + $signed({1'b0, mulx_rsp.prod}));
    if (xsum[DW+1:DW-1] == 3'b000 || xsum[DW+1:DW-1] == 3'b111) begin
      x_new = xsum[DW-1:0];
    end else if (xsum[DW+1]) begin
      x_new = {1'b1, {(DW-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Filter state: reloaded on any register write, updated when a result is stored.
  always_comb begin
    x_nxt = x_r;
    p_nxt = p_r;
    if (cfg_wr) begin
      x_nxt = (cfg_idx == REG_X0) ? pwdata : x0_r;
      p_nxt = (cfg_idx == REG_P0) ? pwdata : p0_r;
    end else if (load) begin
      x_nxt = x_new;
      p_nxt = mulp_rsp.prod[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      p_r <= 32'd65536;
    end else begin
      x_r <= x_nxt;
      p_r <= p_nxt;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r <= x_new;
      out_k_r <= div_rsp.k;
      out_p_r <= mulp_rsp.prod[DW-1:0];
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.estimate    = out_x_r;
  assign out_ch.kalman_gain = out_k_r;
  assign out_ch.covariance  = out_p_r;

  // An accepted measurement always moves the sequencer into the prediction cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_PRED)
    else $error("accepted measurement did not start a step");

  // The gain never exceeds one.
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_k_r <= Q_ONE)
    else $error("gain above one");

  // The updated covariance never exceeds the predicted covariance.
  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> mulp_rsp.prod <= {1'b0, p1_r})
    else $error("covariance grew in the update");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside its step");

  // A stored result is never overwritten before the sink takes it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

endmodule

FILE: test/scalar_kalman_filter_top_tb.sv
// Self-checking testbench for the scalar Kalman filter: predicts every result and compares it.
module scalar_kalman_filter_top_tb;
  import skf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASE_ITEMS    = 116;
  localparam int unsigned NUM_PHASES     = 8;

  localparam longint unsigned GAIN_ONE = 64'd65536;
  localparam longint unsigned U32_TOP  = 64'h0000_0000_FFFF_FFFF;
  localparam longint          EST_MAX  = 64'sd2147483647;
  localparam longint          EST_MIN  = -64'sd2147483648;

  // One filter step as it leaves the block.
  typedef struct packed {
    logic signed [DW-1:0] estimate;
    logic [KW-1:0]        kalman_gain;
    logic [DW-1:0]        covariance;
  } kalman_result_t;

  // Tracks the filter state and the configuration, and holds the results still to come.
  class kalman_scoreboard;
    logic [DW-1:0]        q_noise;
    logic [DW-1:0]        r_noise;
    logic signed [DW-1:0] x_init;
    logic [DW-1:0]        p_init;
    logic signed [DW-1:0] x_est;
    logic [DW-1:0]        p_cov;
    kalman_result_t       pending_results[$];
    int unsigned          failures;

    function new();
      q_noise  = 32'd65;
      r_noise  = 32'd6554;
      x_init   = '0;
      p_init   = 32'd65536;
      x_est    = x_init;
      p_cov    = p_init;
      failures = 0;
    endfunction

    // A register write stores the value and reloads the estimate and covariance.
    function void write_reg(reg_idx_t idx, logic [DW-1:0] value);
      case (idx)
        REG_Q:  q_noise = value;
        REG_R:  r_noise = value;
        REG_X0: x_init  = value;
        REG_P0: p_init  = value;
        default: ;
      endcase
      x_est = x_init;
      p_cov = p_init;
    endfunction

    // Runs one predict/update step for an accepted measurement.
    function void note_measurement(logic signed [DW-1:0] meas);
      longint unsigned p_pred, denom, gain, mag, corr, p_next;
      longint          innov, x_next;
      kalman_result_t  res;
      p_pred = {32'd0, p_cov} + {32'd0, q_noise};
      if (p_pred > U32_TOP) p_pred = U32_TOP;
      denom = p_pred + {32'd0, r_noise};
      // A zero denominator forces a zero gain.
      gain = (denom == 0) ? 64'd0 : (p_pred << 16) / denom;
      if (gain > GAIN_ONE) gain = GAIN_ONE;
      innov = longint'(meas) - longint'(x_est);
      mag = (innov < 0) ? -innov : innov;
      corr = (gain * mag) >> 16;
      x_next = (innov < 0) ? longint'(x_est) - longint'(corr) : longint'(x_est) + longint'(corr);
      if (x_next > EST_MAX) x_next = EST_MAX;
      if (x_next < EST_MIN) x_next = EST_MIN;
      p_next = ((GAIN_ONE - gain) * p_pred) >> 16;
      if (p_next > U32_TOP) p_next = U32_TOP;
      x_est = x_next[31:0];
      p_cov = p_next[31:0];
      res.estimate    = x_est;
      res.kalman_gain = gain[KW-1:0];
      res.covariance  = p_cov;
      pending_results.push_back(res);
    endfunction

    // Compares a result transaction with the oldest expected one.
    function void check_result(kalman_result_t got);
      kalman_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result est=%0d gain=%0d cov=%0d", $time,
                 got.estimate, got.kalman_gain, got.covariance);
        failures++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.estimate !== exp_res.estimate) begin
        $display("%0t: estimate expected %0d got %0d", $time, exp_res.estimate, got.estimate);
        failures++;
      end
      if (got.kalman_gain !== exp_res.kalman_gain) begin
        $display("%0t: gain expected %0d got %0d", $time, exp_res.kalman_gain,
                 got.kalman_gain);
        failures++;
      end
      if (got.covariance !== exp_res.covariance) begin
        $display("%0t: covariance expected %0d got %0d", $time, exp_res.covariance,
                 got.covariance);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  skf_in_if  in_if ();
  skf_out_if out_if ();

  kalman_scoreboard sb = new();

  int unsigned          tx_idle_pct;
  int unsigned          rx_stall_pct;
  logic                 rx_hold;
  int unsigned          quiet_cycles;
  logic signed [31:0]   track;

  scalar_kalman_filter_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, or fully while a hold-off is active.
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Every accepted transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_measurement(in_if.measurement);
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.estimate, out_if.kalman_gain, out_if.covariance});
      end
    end
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) sb.write_reg(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register and reads it back.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, idx, value, rd);
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== value) begin
      $display("%0t: register %s read expected %0h got %0h", $time, idx.name(), value, rd);
      sb.failures++;
    end
  endtask

  task automatic load_config(input logic [31:0] q, input logic [31:0] r,
                             input logic [31:0] x0, input logic [31:0] p0);
    cfg_write(REG_Q, q);
    cfg_write(REG_R, r);
    cfg_write(REG_X0, x0);
    cfg_write(REG_P0, p0);
  endtask

  // Offers one measurement, with a random idle gap first, and waits for its acceptance.
  task automatic offer_measurement(input logic signed [31:0] meas);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.measurement <= meas;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stops offering and waits until every result is in and the block has settled.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // Noise and covariance values: mostly moderate, sometimes the extremes.
  function automatic logic [31:0] pick_unsigned();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 32'd0;
    if (sel < 20) return 32'hFFFF_FFFF;
    if (sel < 35) return $urandom;
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  // Measurements: a noisy random walk, with some full-range and extreme samples.
  function automatic logic signed [31:0] pick_measurement();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    track = track + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    if (sel < 15) return $urandom;
    if (sel < 20) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return track + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  initial begin
    logic signed [31:0] directed_meas[$];
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.measurement <= '0;
    rx_hold           <= 1'b0;
    rx_stall_pct      <= 0;
    tx_idle_pct       = 0;
    track             = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: extremes of the measurement and the largest innovations.
    directed_meas = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      -32'sd1, 32'sd1, 32'sh0001_0000, -32'sh0001_0000};
    foreach (directed_meas[i]) offer_measurement(directed_meas[i]);
    drain();

    // Zero denominator: no noise and zero covariance keep the gain at zero.
    load_config(32'd0, 32'd0, 32'sh0000_1234, 32'd0);
    offer_measurement(32'sh8000_0000);
    offer_measurement(32'sh7FFF_FFFF);
    drain();

    // Saturated predicted covariance with no measurement noise: unity gain.
    load_config(32'hFFFF_FFFF, 32'd0, 32'sh8000_0000, 32'hFFFF_FFFF);
    offer_measurement(32'sh7FFF_FFFF);
    offer_measurement(32'sh8000_0000);
    offer_measurement(32'sd0);
    drain();

    // Huge measurement noise against a tiny covariance: the gain rounds to zero.
    load_config(32'd0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'd1);
    offer_measurement(32'sh8000_0000);
    offer_measurement(32'sd0);
    drain();

    // Small equal noise terms.
    load_config(32'd1, 32'd1, 32'sd12345, 32'h0001_0000);
    offer_measurement(-32'sd54321);
    offer_measurement(32'sh0100_0000);
    offer_measurement(32'sd7);
    drain();

    // Random phases over the idling modes, each with a fresh configuration.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      load_config(pick_unsigned(), pick_unsigned(), $urandom, pick_unsigned());
      track = $urandom;
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 80;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 80;
        end
        default: begin
          tx_idle_pct = 21;
          rx_stall_pct <= 21;
        end
      endcase
      // The receiver holds off once while the sender keeps offering.
      if (ph == 0) begin
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
      end
      repeat (PHASE_ITEMS) offer_measurement(pick_measurement());
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
